@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the path tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/lpfl_pkg.sv @@
// Types, constants and helper functions of the path tracker.
package lpfl_pkg;

  localparam int PATH_DEPTH = 1024;
  localparam int CONTROL_PERIOD = 3277;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_MAX = 24;
  localparam int CORDIC_N = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
  localparam int IDX_W = $clog2(PATH_DEPTH);
  localparam int CNT_W = $clog2(PATH_DEPTH + 1);
  localparam int STEP_W = $clog2(CORDIC_MAX + 1);

  localparam logic signed [19:0] PI_Q = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_Q = 20'sd411775;
  localparam logic signed [19:0] HALF_PI_Q = 20'sd102944;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  typedef enum logic [2:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEGRAL  = 3'd1,
    REG_GAIN_ROTATE    = 3'd2,
    REG_LOOKAHEAD_DIST = 3'd3,
    REG_PREVIEW_DIST   = 3'd4,
    REG_GOAL_RADIUS    = 3'd5,
    REG_LIMIT_LINEAR   = 3'd6,
    REG_LIMIT_ANGULAR  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [18:0] heading;
    logic               first_point;
  } item_t;

  typedef struct packed {
    logic [23:0] gain_prop;
    logic [23:0] gain_integral;
    logic [23:0] gain_rotate;
    logic [30:0] lookahead_dist;
    logic [30:0] preview_dist;
    logic [30:0] goal_radius;
    logic [30:0] limit_linear;
    logic [30:0] limit_angular;
  } cfg_t;

  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      5'd11:   r = 34'sd524288;
      5'd12:   r = 34'sd262144;
      5'd13:   r = 34'sd131072;
      5'd14:   r = 34'sd65536;
      5'd15:   r = 34'sd32768;
      5'd16:   r = 34'sd16384;
      5'd17:   r = 34'sd8192;
      5'd18:   r = 34'sd4096;
      5'd19:   r = 34'sd2048;
      5'd20:   r = 34'sd1024;
      5'd21:   r = 34'sd512;
      5'd22:   r = 34'sd256;
      5'd23:   r = 34'sd128;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // One correction brings any difference of two headings into [-pi, pi].
  function automatic logic signed [19:0] wrap_angle(input logic signed [19:0] a);
    logic signed [19:0] r;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] v,
                                                   input logic [30:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] r;
    hi = $signed({33'd0, lim});
    if (v > hi) begin
      r = hi;
    end else if (v < -hi) begin
      r = -hi;
    end else begin
      r = v;
    end
    return $signed(r[31:0]);
  endfunction

endpackage

@@ rtl/lpfl_cordic.sv @@
// Iterative CORDIC giving cosine and sine of a heading in Q16.
module lpfl_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [18:0] theta,
  output logic               done,
  output logic signed [19:0] cos_q16,
  output logic signed [19:0] sin_q16
);
  import lpfl_pkg::*;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [STEP_W-1:0]  step;
  logic               run;
  logic               flip;
  logic signed [19:0] th_w;
  logic signed [19:0] th_f;
  logic               fl;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  always_comb begin
    th_w = wrap_angle(20'(theta));
    fl = 1'b0;
    th_f = th_w;
    if (th_w > HALF_PI_Q) begin
      th_f = th_w - PI_Q;
      fl = 1'b1;
    end else if (th_w < -HALF_PI_Q) begin
      th_f = th_w + PI_Q;
      fl = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    xf = flip ? -x : x;
    yf = flip ? -y : y;
    xr = (xf + 34'sd8192) >>> 14;
    yr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        step <= '0;
      end else if (run) begin
        if (step == STEP_W'(CORDIC_N)) begin
          run <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= '0;
      z <= $signed({th_f, 14'd0});
      flip <= fl;
    end else if (run && step != STEP_W'(CORDIC_N)) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q30(step);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q30(step);
      end
    end
    if (run && step == STEP_W'(CORDIC_N)) begin
      cos_q16 <= xr[19:0];
      sin_q16 <= yr[19:0];
    end
  end

endmodule

@@ rtl/lpfl_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module lpfl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import lpfl_pkg::*;

  logic [30:0] rem;
  logic [30:0] den;
  logic [6:0]  cnt;
  logic        run;
  logic [31:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, quotient[63]};
    fits = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 7'd63) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quotient <= dividend;
    end else if (run) begin
      rem <= fits ? 31'(trial - {1'b0, den}) : trial[30:0];
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

@@ rtl/lpfl_front.sv @@
// Front end: takes requests and queues them for the execution unit.
module lpfl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lpfl_pkg::item_t item_in,
  input  logic            pop,
  output logic            busy,
  output logic            head_valid,
  output lpfl_pkg::item_t head
);
  import lpfl_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       take;

  always_comb begin
    busy = cnt == 2'd2;
    head_valid = cnt != 2'd0;
    head = slots[rp];
    push = start && !busy;
    take = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (take) begin
        rp <= ~rp;
      end
      if (push && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item_in;
    end
  end

endmodule

@@ rtl/lpfl_back.sv @@
// Execution unit: path store, target search, PI control and output mapping.
module lpfl_back (
  input  logic               clk,
  input  logic               rst,
  input  lpfl_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  lpfl_pkg::item_t    head,
  output logic               pop,
  output logic               done,
  output logic signed [31:0] linear_cmd,
  output logic signed [31:0] angular_cmd,
  output logic               at_goal,
  output logic               status
);
  import lpfl_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_PREP    = 18'h00002,
    S_SQ      = 18'h00004,
    S_THRESH  = 18'h00008,
    S_GOALCHK = 18'h00010,
    S_ROTATE  = 18'h00020,
    S_SEARCH  = 18'h00040,
    S_FETCH   = 18'h00080,
    S_TGT     = 18'h00100,
    S_ERR     = 18'h00200,
    S_INTMUL  = 18'h00400,
    S_INTACC  = 18'h00800,
    S_GAINMUL = 18'h01000,
    S_VEL     = 18'h02000,
    S_PROJ    = 18'h04000,
    S_OUT     = 18'h08000,
    S_DIV     = 18'h10000,
    S_SPARE   = 18'h20000
  } state_t;

  state_t state;

  logic signed [31:0] mem_x [PATH_DEPTH];
  logic signed [31:0] mem_y [PATH_DEPTH];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] px_rd;
  logic signed [31:0] py_rd;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   base;
  logic [CNT_W-1:0]   last;
  logic [CNT_W-1:0]   iss_idx;
  logic [IDX_W-1:0]   t_idx;
  logic signed [18:0] goal_yaw;
  logic signed [31:0] integral_x;
  logic signed [31:0] integral_y;

  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [18:0] pose_hd;

  logic               vld1;
  logic               vld2;
  logic               vld3;
  logic [IDX_W-1:0]   idx1;
  logic [IDX_W-1:0]   idx2;
  logic [IDX_W-1:0]   idx3;
  logic [31:0]        mag_x;
  logic [31:0]        mag_y;
  logic [63:0]        sq_x;
  logic [63:0]        sq_y;
  logic [64:0]        sq_sum;
  logic [63:0]        d2;
  logic [63:0]        r2;
  logic [63:0]        la2;
  logic signed [32:0] dxw;
  logic signed [32:0] dyw;

  logic               cor_start;
  logic               cor_done;
  logic signed [19:0] cor_c;
  logic signed [19:0] cor_s;
  logic signed [19:0] c_q;
  logic signed [19:0] s_q;
  logic               cs_ready;

  logic signed [44:0] rot_prod;
  logic signed [44:0] rot_rnd;
  logic signed [19:0] e_goal;

  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic signed [51:0] pcx;
  logic signed [51:0] pcy;
  logic signed [51:0] pcx_r;
  logic signed [51:0] pcy_r;
  logic signed [37:0] ex;
  logic signed [37:0] ey;
  logic signed [51:0] ipx;
  logic signed [51:0] ipy;
  logic signed [51:0] ipx_r;
  logic signed [51:0] ipy_r;
  logic signed [39:0] isum_x;
  logic signed [39:0] isum_y;
  logic signed [63:0] gpx;
  logic signed [63:0] gpy;
  logic signed [63:0] gix;
  logic signed [63:0] giy;
  logic signed [63:0] vsum_x;
  logic signed [63:0] vsum_y;
  logic signed [47:0] vx;
  logic signed [47:0] vy;
  logic signed [67:0] p_vxc;
  logic signed [67:0] p_vys;
  logic signed [67:0] p_vyc;
  logic signed [67:0] p_vxs;
  logic signed [67:0] lin_sum;
  logic signed [67:0] num;
  logic               num_neg;
  logic signed [31:0] lin_hold;

  logic               div_start;
  logic [63:0]        div_mag;
  logic [30:0]        div_den;
  logic               div_done;
  logic [63:0]        div_quo;
  logic signed [63:0] quo_s;

  lpfl_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .theta   (head.heading),
    .done    (cor_done),
    .cos_q16 (cor_c),
    .sin_q16 (cor_s)
  );

  lpfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    base = head.first_point ? '0 : count;
    last = count - 1'b1;
    mem_waddr = base[IDX_W-1:0];
    pop = 1'b0;
    mem_we = 1'b0;
    rd_en = 1'b0;
    rd_addr = iss_idx[IDX_W-1:0];
    cor_start = 1'b0;
    div_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.kind == KIND_LOAD && base < CNT_W'(PATH_DEPTH)) begin
            mem_we = 1'b1;
          end
          if (head.kind == KIND_CONTROL && count != '0) begin
            cor_start = 1'b1;
          end
        end
      end
      S_THRESH: begin
        rd_en = 1'b1;
        rd_addr = last[IDX_W-1:0];
      end
      S_SEARCH: begin
        rd_en = iss_idx < count;
      end
      S_FETCH: begin
        rd_en = 1'b1;
        rd_addr = t_idx;
      end
      S_OUT: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase

    dxw = 33'(pose_x) - 33'(px_rd);
    dyw = 33'(pose_y) - 33'(py_rd);
    sq_sum = 65'(sq_x) + 65'(sq_y);
    d2 = sq_sum[64] ? '1 : sq_sum[63:0];

    rot_rnd = (rot_prod + 45'sd32768) >>> 16;
    pcx_r = (pcx + 52'sd32768) >>> 16;
    pcy_r = (pcy + 52'sd32768) >>> 16;
    ipx_r = (ipx + 52'sd32768) >>> 16;
    ipy_r = (ipy + 52'sd32768) >>> 16;
    isum_x = 40'(integral_x) + 40'(ipx_r);
    isum_y = 40'(integral_y) + 40'(ipy_r);
    vsum_x = gpx + gix;
    vsum_y = gpy + giy;
    lin_sum = (p_vxc + p_vys + 68'sd32768) >>> 16;
    num = p_vyc - p_vxs;
    div_mag = num[67] ? 64'(-num) : 64'(num);
    div_den = (cfg.preview_dist == '0) ? 31'd1 : cfg.preview_dist;
    quo_s = num_neg ? -$signed(div_quo) : $signed(div_quo);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_waddr] <= head.pos_x;
      mem_y[mem_waddr] <= head.pos_y;
    end
    if (rd_en) begin
      px_rd <= mem_x[rd_addr];
      py_rd <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= rd_en;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= rd_addr;
    idx2 <= idx1;
    idx3 <= idx2;
    if (state == S_PREP) begin
      mag_x <= {1'b0, cfg.goal_radius};
      mag_y <= {1'b0, cfg.lookahead_dist};
    end else begin
      mag_x <= dxw[32] ? 32'(-dxw) : dxw[31:0];
      mag_y <= dyw[32] ? 32'(-dyw) : dyw[31:0];
    end
    sq_x <= 64'(mag_x) * 64'(mag_x);
    sq_y <= 64'(mag_y) * 64'(mag_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      goal_yaw <= '0;
      integral_x <= '0;
      integral_y <= '0;
      cs_ready <= 1'b0;
      done <= 1'b0;
      iss_idx <= '0;
    end else begin
      done <= 1'b0;
      if (cor_start) begin
        cs_ready <= 1'b0;
      end else if (cor_done) begin
        cs_ready <= 1'b1;
      end
      if (rd_en && state == S_SEARCH) begin
        iss_idx <= iss_idx + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            if (head.kind == KIND_LOAD) begin
              if (head.first_point) begin
                integral_x <= '0;
                integral_y <= '0;
              end
              if (base < CNT_W'(PATH_DEPTH)) begin
                count <= base + 1'b1;
                goal_yaw <= head.heading;
              end else begin
                count <= base;
              end
            end else if (count == '0) begin
              done <= 1'b1;
              linear_cmd <= '0;
              angular_cmd <= '0;
              at_goal <= 1'b0;
              status <= 1'b1;
            end else begin
              pose_x <= head.pos_x;
              pose_y <= head.pos_y;
              pose_hd <= head.heading;
              state <= S_PREP;
            end
          end
        end
        S_PREP: state <= S_SQ;
        S_SQ: state <= S_THRESH;
        S_THRESH: begin
          r2 <= sq_x;
          la2 <= sq_y;
          state <= S_GOALCHK;
        end
        S_GOALCHK: begin
          if (vld3) begin
            if (d2 < r2) begin
              e_goal <= wrap_angle(20'(goal_yaw) - 20'(pose_hd));
              state <= S_ROTATE;
            end else begin
              iss_idx <= '0;
              state <= S_SEARCH;
            end
          end
        end
        S_ROTATE: begin
          if (rot_prod == rot_prod && e_goal == e_goal) begin
            state <= S_SPARE;
          end
        end
        S_SPARE: begin
          done <= 1'b1;
          linear_cmd <= '0;
          angular_cmd <= clamp_lim(64'(rot_rnd), cfg.limit_angular);
          at_goal <= 1'b1;
          status <= 1'b0;
          state <= S_IDLE;
        end
        S_SEARCH: begin
          if (vld3) begin
            if (d2 >= la2) begin
              t_idx <= idx3;
              state <= S_FETCH;
            end else if (idx3 == last[IDX_W-1:0]) begin
              t_idx <= last[IDX_W-1:0];
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_TGT;
        S_TGT: begin
          if (cs_ready) begin
            tx <= px_rd;
            ty <= py_rd;
            c_q <= cor_c;
            s_q <= cor_s;
            pcx <= 52'($signed({1'b0, cfg.preview_dist})) * 52'(cor_c);
            pcy <= 52'($signed({1'b0, cfg.preview_dist})) * 52'(cor_s);
            state <= S_ERR;
          end
        end
        S_ERR: begin
          ex <= 38'(tx) - 38'(pose_x) - 38'(pcx_r);
          ey <= 38'(ty) - 38'(pose_y) - 38'(pcy_r);
          state <= S_INTMUL;
        end
        S_INTMUL: begin
          ipx <= 52'(ex) * 52'(CONTROL_PERIOD);
          ipy <= 52'(ey) * 52'(CONTROL_PERIOD);
          state <= S_INTACC;
        end
        S_INTACC: begin
          integral_x <= sat32(isum_x);
          integral_y <= sat32(isum_y);
          state <= S_GAINMUL;
        end
        S_GAINMUL: begin
          gpx <= 64'($signed({1'b0, cfg.gain_prop})) * 64'(ex);
          gpy <= 64'($signed({1'b0, cfg.gain_prop})) * 64'(ey);
          gix <= 64'($signed({1'b0, cfg.gain_integral})) * 64'(integral_x);
          giy <= 64'($signed({1'b0, cfg.gain_integral})) * 64'(integral_y);
          state <= S_VEL;
        end
        S_VEL: begin
          vx <= 48'((vsum_x + 64'sd32768) >>> 16);
          vy <= 48'((vsum_y + 64'sd32768) >>> 16);
          state <= S_PROJ;
        end
        S_PROJ: begin
          p_vxc <= 68'(vx) * 68'(c_q);
          p_vys <= 68'(vy) * 68'(s_q);
          p_vyc <= 68'(vy) * 68'(c_q);
          p_vxs <= 68'(vx) * 68'(s_q);
          state <= S_OUT;
        end
        S_OUT: begin
          lin_hold <= clamp_lim(64'(lin_sum), cfg.limit_linear);
          num_neg <= num[67];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            done <= 1'b1;
            linear_cmd <= lin_hold;
            angular_cmd <= clamp_lim(quo_s, cfg.limit_angular);
            at_goal <= 1'b0;
            status <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GOALCHK) begin
      rot_prod <= 45'(wrap_angle(20'(goal_yaw) - 20'(pose_hd)))
                  * 45'($signed({1'b0, cfg.gain_rotate}));
    end
  end

endmodule

@@ rtl/lookahead_pi_feedback_linearization_top.sv @@
// Top level of the path tracker: configuration registers, front end and execution unit.
//
// Channel   Direction  Handshake             Payload
// request   in         start and not busy    kind, pos_x, pos_y, heading, first_point
// result    out        done, one cycle       linear_cmd, angular_cmd, at_goal, status
// config    in         cfg_write             cfg_index, cfg_data
//
// A request leaves the queue once the execution unit is idle; a load, or a control request on an
// empty path, is then completed in the idle state.
// Near the goal, done follows from S_PREP, S_SQ, S_THRESH, S_GOALCHK, S_ROTATE and S_SPARE.
// Otherwise the search walks the stored points, the target state waits for the CORDIC, and
// the PI and projection states feed the divider before done rises.
// Reset is synchronous and clears the path count, the integrators and the goal heading.
// A two-entry queue accepts requests while the execution unit works; busy is high when it is full.
`include "assert_macros.svh"
module lookahead_pi_feedback_linearization_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [18:0] heading,
  input  logic               first_point,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] linear_cmd,
  output logic signed [31:0] angular_cmd,
  output logic               at_goal,
  output logic               status
);
  import lpfl_pkg::*;

  cfg_t  cfg;
  item_t item_in;
  item_t head;
  logic  head_valid;
  logic  pop;

  always_comb begin
    item_in.kind = kind;
    item_in.pos_x = pos_x;
    item_in.pos_y = pos_y;
    item_in.heading = heading;
    item_in.first_point = first_point;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop <= 24'd131072;
      cfg.gain_integral <= 24'd65536;
      cfg.gain_rotate <= 24'd65536;
      cfg.lookahead_dist <= 31'd16384;
      cfg.preview_dist <= 31'd6554;
      cfg.goal_radius <= 31'd9830;
      cfg.limit_linear <= 31'd13107;
      cfg.limit_angular <= 31'd117965;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_PROP:      cfg.gain_prop <= cfg_data[23:0];
        REG_GAIN_INTEGRAL:  cfg.gain_integral <= cfg_data[23:0];
        REG_GAIN_ROTATE:    cfg.gain_rotate <= cfg_data[23:0];
        REG_LOOKAHEAD_DIST: cfg.lookahead_dist <= cfg_data;
        REG_PREVIEW_DIST:   cfg.preview_dist <= cfg_data;
        REG_GOAL_RADIUS:    cfg.goal_radius <= cfg_data;
        REG_LIMIT_LINEAR:   cfg.limit_linear <= cfg_data;
        REG_LIMIT_ANGULAR:  cfg.limit_angular <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lpfl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item_in    (item_in),
    .pop        (pop),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head)
  );

  lpfl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .linear_cmd  (linear_cmd),
    .angular_cmd (angular_cmd),
    .at_goal     (at_goal),
    .status      (status)
  );

  `ASSERT_IMPLIES(a_empty_zero, clk, rst, done && status, linear_cmd == 32'sd0 && angular_cmd == 32'sd0 && !at_goal)
  `ASSERT_IMPLIES(a_goal_still, clk, rst, done && at_goal, linear_cmd == 32'sd0)
  `ASSERT_NEXT(a_busy_full, clk, rst, busy && !pop, busy)

endmodule
